// File: rtl/cme_pkg.sv
package cme_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DIM_BITS    = 3;
   localparam int MAX_POINTS  = 65536;
   localparam int CNT_BITS    = 17;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int COV_BITS    = 39;
   localparam int DSUM_BITS   = 32;
   localparam int PSUM_BITS   = 48;
   localparam int PAIR_DEPTH  = MAX_DIM * MAX_DIM;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COV_BITS-1:0]    cov_type;
   typedef logic [DIM_BITS-1:0]           index_type;
   typedef logic [3:0]                    dims_type;
   typedef logic [1:0]                    status_type;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_PARTIAL  = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_CAPACITY = 2'd3;

endpackage

// File: rtl/cme_req_if.sv
interface cme_req_if;
   logic                 valid;
   logic                 ready;
   cme_pkg::sample_type  sample;
   logic                 end_of_set;

   modport source (output valid, sample, end_of_set, input ready);
   modport sink   (input valid, sample, end_of_set, output ready);
endinterface

// File: rtl/cme_rsp_if.sv
interface cme_rsp_if;
   logic                 valid;
   logic                 ready;
   cme_pkg::index_type   row;
   cme_pkg::index_type   col;
   cme_pkg::cov_type     covariance;
   cme_pkg::status_type  status;
   logic                 last;

   modport source (output valid, row, col, covariance, status, last, input ready);
   modport sink   (input valid, row, col, covariance, status, last, output ready);
endinterface

// File: rtl/cme_ram.sv
module cme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/covariance_matrix_engine_unit.sv
// Population covariance matrix engine. Coordinates arrive one item at a time,
// dims_in_use of them per point. When an item completes a point, the point is
// folded into the sums by one multiply-add that walks the pair-sum memory.
// The item with end_of_set then produces dims*dims entries in row-major order.
// Each entry is formed by a product in two halves and then the 39-step
// restoring divider; an entry that saturates, or any entry of an empty set,
// skips the divider. Every row first reads its dimension sum, and a stalled
// output holds the engine until the entry is taken.
// Sums live in single-port-read memories with per-entry valid bits, so the
// clear after a run only resets the valid bits. Input is not taken while a
// point is folded in or the matrix is being sent.
module covariance_matrix_engine_unit (
   input  logic               clock,
   input  logic               reset,
   cme_req_if.sink            req_if,
   cme_rsp_if.source          rsp_if,
   input  logic               csr_we,
   input  cme_pkg::dims_type  csr_wdata
);
   import cme_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_AROW   = 4'd1;
   localparam logic [3:0] S_AVA    = 4'd2;
   localparam logic [3:0] S_AMAC   = 4'd3;
   localparam logic [3:0] S_OSTART = 4'd4;
   localparam logic [3:0] S_OROW   = 4'd5;
   localparam logic [3:0] S_OSX    = 4'd6;
   localparam logic [3:0] S_ORD    = 4'd7;
   localparam logic [3:0] S_OMUL   = 4'd8;
   localparam logic [3:0] S_OSUB   = 4'd9;
   localparam logic [3:0] S_ODIV   = 4'd10;
   localparam logic [3:0] S_OEMIT  = 4'd11;
   localparam logic [3:0] S_OMH    = 4'd12;

   localparam logic [COV_BITS-1:0] LIM_NEG = {1'b1, {(COV_BITS-1){1'b0}}};
   localparam logic [COV_BITS-1:0] LIM_POS = {1'b0, {(COV_BITS-1){1'b1}}};

   logic [3:0]              state_ff, state_in;
   dims_type                dims_ff;
   dims_type                dact;
   index_type               coord_ff, coord_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    cap_ff, cap_in;
   logic                    eos_ff, eos_in;
   index_type               a_ff, a_in;
   index_type               b_ff, b_in;
   logic [MAX_DIM-1:0]      dvalid_ff, dvalid_in;
   logic [PAIR_DEPTH-1:0]   pvalid_ff, pvalid_in;
   logic                    rdv_ff, rpv_ff;
   sample_type              va_ff, va_in;
   logic signed [DSUM_BITS-1:0] sx_ff, sx_in;
   status_type              status_ff, status_in;
   logic signed [63:0]      p1_ff, p1_in;
   logic signed [63:0]      p2_ff, p2_in;
   logic [32:0]             den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic                    sat_ff, sat_in;
   logic [32:0]             rem_ff, rem_in;
   logic [38:0]             nsh_ff, nsh_in;
   logic [38:0]             q_ff, q_in;
   logic [5:0]              step_ff, step_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   index_type               rsp_row_ff, rsp_row_in;
   index_type               rsp_col_ff, rsp_col_in;
   cov_type                 rsp_cov_ff, rsp_cov_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    buf_we;
   index_type               buf_waddr, buf_raddr;
   sample_type              buf_wdata, buf_rdata;
   logic                    dim_we;
   index_type               dim_waddr, dim_raddr;
   logic [DSUM_BITS-1:0]    dim_wdata, dim_rdata;
   logic                    pair_we;
   logic [5:0]              pair_waddr, pair_raddr;
   logic [PSUM_BITS-1:0]    pair_wdata, pair_rdata;

   logic                    accept;
   logic                    out_free;
   logic signed [DSUM_BITS-1:0] dsum_rd;
   logic signed [PSUM_BITS-1:0] psum_rd;
   logic signed [31:0]      prod;
   logic signed [42:0]      p1_lo;
   logic signed [41:0]      p1_hi;
   logic [33:0]             den_full;
   logic signed [63:0]      num;
   logic [63:0]             mag;
   logic [33:0]             r2;
   logic [COV_BITS-1:0]     res_mag;
   logic                    b_more, a_more;

   cme_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DIM)) u_buf (
      .clock(clock), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
      .raddr(buf_raddr), .rdata(buf_rdata)
   );
   cme_ram #(.WIDTH(DSUM_BITS), .DEPTH(MAX_DIM)) u_dim (
      .clock(clock), .we(dim_we), .waddr(dim_waddr), .wdata(dim_wdata),
      .raddr(dim_raddr), .rdata(dim_rdata)
   );
   cme_ram #(.WIDTH(PSUM_BITS), .DEPTH(PAIR_DEPTH)) u_pair (
      .clock(clock), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
      .raddr(pair_raddr), .rdata(pair_rdata)
   );

   assign dact = (dims_ff == 4'd0) ? 4'd1 :
                 (dims_ff > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dims_ff;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept = req_if.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.row        = rsp_row_ff;
   assign rsp_if.col        = rsp_col_ff;
   assign rsp_if.covariance = rsp_cov_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.last       = rsp_last_ff;

   // Invalid entries read as zero, which stands for the cleared sums.
   assign dsum_rd = rdv_ff ? $signed(dim_rdata) : '0;
   assign psum_rd = rpv_ff ? $signed(pair_rdata) : '0;
   assign prod    = va_ff * $signed(buf_rdata);
   // The count times the pair sum is formed in two halves, in S_OMUL and S_OMH.
   assign p1_lo   = $signed({1'b0, count_ff}) * $signed({1'b0, psum_rd[23:0]});
   assign p1_hi   = $signed({1'b0, count_ff}) * $signed(psum_rd[PSUM_BITS-1:24]);
   assign den_full = count_ff * count_ff;
   assign num     = p1_ff - p2_ff;
   assign mag     = num[63] ? 64'(-num) : num;
   assign r2      = {rem_ff, nsh_ff[38]};
   assign b_more  = ({1'b0, b_ff} + 4'd1) < dact;
   assign a_more  = ({1'b0, a_ff} + 4'd1) < dact;

   always_comb begin
      if (sat_ff) begin
         res_mag = neg_ff ? LIM_NEG : LIM_POS;
      end else if (!neg_ff && q_ff > LIM_POS) begin
         res_mag = LIM_POS;
      end else if (neg_ff && q_ff > LIM_NEG) begin
         res_mag = LIM_NEG;
      end else begin
         res_mag = q_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      coord_in   = coord_ff;
      count_in   = count_ff;
      cap_in     = cap_ff;
      eos_in     = eos_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      dvalid_in  = dvalid_ff;
      pvalid_in  = pvalid_ff;
      va_in      = va_ff;
      sx_in      = sx_ff;
      status_in  = status_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      nsh_in     = nsh_ff;
      q_in       = q_ff;
      step_in    = step_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_cov_in    = rsp_cov_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      buf_we     = accept;
      buf_waddr  = coord_ff;
      buf_wdata  = req_if.sample;
      buf_raddr  = a_ff;
      dim_we     = 1'b0;
      dim_waddr  = a_ff;
      dim_wdata  = 32'(dsum_rd + DSUM_BITS'(buf_rdata));
      dim_raddr  = a_ff;
      pair_we    = 1'b0;
      pair_waddr = {a_ff, b_ff};
      pair_wdata = 48'(psum_rd + PSUM_BITS'(prod));
      pair_raddr = {a_ff, b_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               eos_in = req_if.end_of_set;
               a_in   = '0;
               if (({1'b0, coord_ff} + 4'd1) >= dact) begin
                  coord_in = '0;
                  if (count_ff < CNT_BITS'(MAX_POINTS)) begin
                     state_in = S_AROW;
                  end else begin
                     cap_in   = 1'b1;
                     state_in = req_if.end_of_set ? S_OSTART : S_IDLE;
                  end
               end else begin
                  coord_in = coord_ff + 3'd1;
                  state_in = req_if.end_of_set ? S_OSTART : S_IDLE;
               end
            end
         end
         S_AROW: begin
            buf_raddr = a_ff;
            dim_raddr = a_ff;
            state_in  = S_AVA;
         end
         S_AVA: begin
            va_in     = buf_rdata;
            dim_we    = 1'b1;
            dvalid_in[a_ff] = 1'b1;
            b_in       = '0;
            buf_raddr  = '0;
            pair_raddr = {a_ff, 3'd0};
            state_in   = S_AMAC;
         end
         S_AMAC: begin
            pair_we = 1'b1;
            pvalid_in[{a_ff, b_ff}] = 1'b1;
            buf_raddr  = b_ff + 3'd1;
            pair_raddr = {a_ff, b_ff + 3'd1};
            if (b_more) begin
               b_in = b_ff + 3'd1;
            end else if (a_more) begin
               a_in     = a_ff + 3'd1;
               state_in = S_AROW;
            end else begin
               count_in = count_ff + 17'd1;
               state_in = eos_ff ? S_OSTART : S_IDLE;
            end
         end
         S_OSTART: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (cap_ff) begin
               status_in = ST_CAPACITY;
            end else if (coord_ff != '0) begin
               status_in = ST_PARTIAL;
            end else begin
               status_in = ST_OK;
            end
            a_in     = '0;
            b_in     = '0;
            state_in = S_OROW;
         end
         S_OROW: begin
            dim_raddr = a_ff;
            state_in  = S_OSX;
         end
         S_OSX: begin
            sx_in    = dsum_rd;
            state_in = S_ORD;
         end
         S_ORD: begin
            dim_raddr  = b_ff;
            pair_raddr = {a_ff, b_ff};
            state_in   = S_OMUL;
         end
         S_OMUL: begin
            p1_in    = 64'(p1_lo);
            p2_in    = sx_ff * dsum_rd;
            den_in   = den_full[32:0];
            state_in = S_OMH;
         end
         S_OMH: begin
            p1_in    = p1_ff + (64'(p1_hi) <<< 24);
            state_in = S_OSUB;
         end
         S_OSUB: begin
            neg_in  = num[63];
            rem_in  = mag[63:31];
            nsh_in  = {mag[30:0], {FRAC_BITS{1'b0}}};
            q_in    = '0;
            step_in = 6'd38;
            // A first partial remainder at or above n^2 means the quotient
            // cannot fit, so the entry saturates without dividing.
            sat_in  = (mag[63:31] >= den_ff);
            state_in = (count_ff == '0 || mag[63:31] >= den_ff) ? S_OEMIT : S_ODIV;
         end
         S_ODIV: begin
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = 33'(r2 - {1'b0, den_ff});
               q_in   = {q_ff[37:0], 1'b1};
            end else begin
               rem_in = r2[32:0];
               q_in   = {q_ff[37:0], 1'b0};
            end
            nsh_in  = {nsh_ff[37:0], 1'b0};
            step_in = step_ff - 6'd1;
            if (step_ff == '0) begin
               sat_in   = 1'b0;
               state_in = S_OEMIT;
            end
         end
         S_OEMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = a_ff;
               rsp_col_in    = b_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = !a_more && !b_more;
               if (count_ff == '0) begin
                  rsp_cov_in = '0;
               end else begin
                  rsp_cov_in = neg_ff ? cov_type'(-res_mag) : cov_type'(res_mag);
               end
               if (b_more) begin
                  b_in     = b_ff + 3'd1;
                  state_in = S_ORD;
               end else if (a_more) begin
                  a_in     = a_ff + 3'd1;
                  b_in     = '0;
                  state_in = S_OROW;
               end else begin
                  coord_in  = '0;
                  count_in  = '0;
                  cap_in    = 1'b0;
                  dvalid_in = '0;
                  pvalid_in = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dims_ff      <= 4'd4;
         coord_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= 1'b0;
         eos_ff       <= 1'b0;
         dvalid_ff    <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            dims_ff <= csr_wdata;
         end
         coord_ff     <= coord_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         eos_ff       <= eos_in;
         dvalid_ff    <= dvalid_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      rdv_ff        <= dvalid_ff[dim_raddr];
      rpv_ff        <= pvalid_ff[pair_raddr];
      va_ff         <= va_in;
      sx_ff         <= sx_in;
      status_ff     <= status_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      rem_ff        <= rem_in;
      nsh_ff        <= nsh_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_cov_ff    <= rsp_cov_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end
endmodule

// File: tb/cme_matrix_checker.sv
`timescale 1ns / 100ps
module cme_matrix_checker (
   input  logic               clock,
   input  logic               reset,
   cme_req_if                 req_if,
   cme_rsp_if                 rsp_if,
   input  logic               csr_we,
   input  cme_pkg::dims_type  csr_wdata,
   output int                 fail_count,
   output int                 outstanding,
   output int                 entries_checked
);
   import cme_pkg::*;

   typedef struct {
      index_type  row;
      index_type  col;
      cov_type    covariance;
      status_type status;
      logic       last;
   } matrix_entry_type;

   matrix_entry_type pending_entries[$];

   dims_type    dims_reg;
   sample_type  coord_buf[MAX_DIM];
   int unsigned coord_pos;
   int unsigned point_total;
   bit          over_capacity;
   logic [63:0] sum_x[MAX_DIM];
   logic [63:0] sum_xy[PAIR_DEPTH];

   function automatic int unsigned effective_dims(dims_type v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic logic [63:0] widen(sample_type s);
      return {{(64-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

   // Population covariance in fixed point, truncated toward zero and saturated.
   function automatic cov_type covariance_of(logic [63:0] n, logic [63:0] sx,
                                             logic [63:0] sy, logic [63:0] sxy);
      logic [63:0] num, mag, den, ip, rem, res, lim;
      logic        neg;
      num = n * sxy - sx * sy;
      neg = num[63];
      mag = neg ? -num : num;
      den = n * n;
      ip  = mag / den;
      rem = mag % den;
      lim = neg ? (64'd1 << (COV_BITS-1)) : ((64'd1 << (COV_BITS-1)) - 1);
      if (ip > ((64'd1 << (COV_BITS-1)) >> FRAC_BITS)) begin
         res = lim;
      end else begin
         res = (ip << FRAC_BITS) + ((rem << FRAC_BITS) / den);
         if (res > lim) res = lim;
      end
      res = neg ? -res : res;
      return res[COV_BITS-1:0];
   endfunction

   task automatic clear_sums();
      coord_pos = 0;
      point_total = 0;
      over_capacity = 0;
      for (int i = 0; i < MAX_DIM; i++) sum_x[i] = '0;
      for (int i = 0; i < PAIR_DEPTH; i++) sum_xy[i] = '0;
   endtask

   task automatic take_coordinate(sample_type s, logic eos);
      int unsigned      d;
      status_type       st;
      matrix_entry_type e;
      d = effective_dims(dims_reg);
      coord_buf[coord_pos % MAX_DIM] = s;
      if (coord_pos + 1 >= d) begin
         if (point_total < MAX_POINTS) begin
            for (int a = 0; a < d; a++) begin
               sum_x[a] += widen(coord_buf[a]);
               for (int b = 0; b < d; b++)
                  sum_xy[a*MAX_DIM+b] += widen(coord_buf[a]) * widen(coord_buf[b]);
            end
            point_total++;
         end else begin
            over_capacity = 1;
         end
         coord_pos = 0;
      end else begin
         coord_pos++;
      end
      if (!eos) return;
      if (point_total == 0) st = ST_EMPTY;
      else if (over_capacity) st = ST_CAPACITY;
      else if (coord_pos != 0) st = ST_PARTIAL;
      else st = ST_OK;
      for (int a = 0; a < d; a++) begin
         for (int b = 0; b < d; b++) begin
            e.row = index_type'(a);
            e.col = index_type'(b);
            e.covariance = (point_total == 0) ? '0 :
               covariance_of(64'(point_total), sum_x[a], sum_x[b], sum_xy[a*MAX_DIM+b]);
            e.status = st;
            e.last = (a == d-1) && (b == d-1);
            pending_entries = {pending_entries, e};
         end
      end
      clear_sums();
   endtask

   task automatic report(string what, matrix_entry_type e);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch: %s; expected row %0d col %0d cov %0d status %0d last %0d,",
                  $time, what, e.row, e.col, e.covariance, e.status, e.last,
                  " got row %0d col %0d cov %0d status %0d last %0d",
                  rsp_if.row, rsp_if.col, rsp_if.covariance, rsp_if.status,
                  rsp_if.last);
   endtask

   initial begin
      fail_count = 0;
      entries_checked = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      matrix_entry_type e;
      if (reset) begin
         dims_reg = 4'd4;
         clear_sums();
         pending_entries.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            entries_checked++;
            if (pending_entries.size() == 0) begin
               e = '{default: '0};
               report("unexpected entry", e);
            end else begin
               e = pending_entries.pop_front();
               if (rsp_if.row !== e.row || rsp_if.col !== e.col ||
                   rsp_if.covariance !== e.covariance ||
                   rsp_if.status !== e.status || rsp_if.last !== e.last)
                  report("entry differs", e);
            end
         end
         if (req_if.valid && req_if.ready)
            take_coordinate(req_if.sample, req_if.end_of_set);
         if (csr_we) dims_reg = csr_wdata;
      end
      outstanding <= pending_entries.size();
   end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import cme_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 600;

   logic     clock;
   logic     reset;
   logic     csr_we;
   dims_type csr_wdata;
   int       fail_count, outstanding, entries_checked;
   int       items_sent, sets_sent, idle_cycles;
   int       burst_left;
   logic     hold_request;
   int       hold_left, pattern_left, pattern_mode;

   cme_req_if req_if ();
   cme_rsp_if rsp_if ();

   covariance_matrix_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   cme_matrix_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .entries_checked (entries_checked)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: changing stall patterns, plus a long hold-off on request.
   initial begin
      rsp_if.ready = 0;
      hold_left = 0;
      pattern_left = 0;
      pattern_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_request) hold_left = HOLD_CYCLES;
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 2);
            pattern_left = $urandom_range(16, 128);
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 0;
         end else begin
            case (pattern_mode)
               0: rsp_if.ready <= 1;
               1: rsp_if.ready <= $urandom_range(0, 1);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL covariance_matrix_engine_unit");
         $finish;
      end
   end

   task automatic send_coordinate(sample_type s, logic eos);
      req_if.valid <= 1;
      req_if.sample <= s;
      req_if.end_of_set <= eos;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (eos) sets_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Waits until every matrix entry is back and any point fold has finished.
   task automatic wait_idle();
      req_if.valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_dims(dims_type v);
      wait_idle();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         4: return sample_type'($urandom_range(0, 15) - 8);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // Sends a set of complete points at the current width, optionally cut short.
   task automatic send_set(int unsigned dims, int points, bit partial);
      int coords;
      coords = points * dims;
      if (partial && dims > 1) coords += $urandom_range(1, dims - 1);
      if (coords == 0) coords = 1;
      for (int i = 0; i < coords; i++)
         send_coordinate(pick_sample(), i == coords - 1);
   endtask

   initial begin
      int unsigned dims;
      dims_type    setting;
      reset = 1;
      csr_we = 0;
      csr_wdata = '0;
      req_if.valid = 0;
      req_if.sample = '0;
      req_if.end_of_set = 0;
      hold_request = 0;
      items_sent = 0;
      sets_sent = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Extreme coordinates at the reset width of four.
      send_coordinate(16'sh7fff, 0);
      send_coordinate(16'sh8000, 0);
      send_coordinate(16'sh0000, 0);
      send_coordinate(16'shffff, 0);
      send_coordinate(16'sh8000, 0);
      send_coordinate(16'sh7fff, 0);
      send_coordinate(16'sh0001, 0);
      send_coordinate(16'sh0000, 1);
      // A lone coordinate with end of set gives the empty status.
      send_coordinate(16'sh1234, 1);
      // One full point then a cut-off one.
      send_set(4, 1, 1);
      // Width zero behaves as one, and fifteen as eight.
      write_dims(4'd0);
      send_set(1, 3, 0);
      write_dims(4'd15);
      send_set(8, 1, 0);
      // The width shrinks and then grows while a point is half done.
      write_dims(4'd8);
      send_coordinate(16'sh0100, 0);
      send_coordinate(16'shff00, 0);
      send_coordinate(16'sh0042, 0);
      write_dims(4'd2);
      send_coordinate(16'sh7fff, 0);
      send_coordinate(16'sh8000, 1);
      send_coordinate(16'sh0005, 0);
      write_dims(4'd8);
      send_set(8, 1, 0);

      // Random sets with random contents.
      dims = 8;
      while (items_sent < 395) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0: setting = 4'd0;
               1: setting = $urandom_range(9, 15);
               default: setting = $urandom_range(1, 8);
            endcase
            write_dims(setting);
            dims = (setting == 0) ? 1 : (setting > 8) ? 8 : setting;
         end
         if (sets_sent == 20) hold_request <= 1;
         send_set(dims, $urandom_range(0, 5), $urandom_range(0, 6) == 0);
         hold_request <= 0;
      end

      wait_idle();
      repeat (200) @(posedge clock);
      $display("Covered %0d coordinates in %0d point sets, %0d matrix entries checked,",
               items_sent, sets_sent, entries_checked);
      $display("with widths 0 to 15, partial and empty sets and long stalls.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS covariance_matrix_engine_unit");
      end else begin
         $display("FAIL covariance_matrix_engine_unit");
      end
      $finish;
   end
endmodule
